@@ rtl/core/bcu_pkg.sv @@
// Shared types and constants of the binomial coefficient unit.
package bcu_pkg;

  localparam int unsigned ResultWidthDef = 32;
  localparam int unsigned ArgWidth       = 32;
  localparam int unsigned CoefWidth      = 32;
  localparam int unsigned ChunkWidth     = 32;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_COEF = 2'd1,
    RES_OVF  = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     mul_start;
    logic     mul_step;
    logic     div_start;
    logic     div_step;
    logic     update;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic k_gt_n;
    logic loop_done;
    logic mul_last;
    logic div_ovf;
    logic div_last;
  } status_t;

endpackage

@@ rtl/core/bcu_dpath.sv @@
// Datapath of the binomial coefficient unit: chunked multiplier and restoring divider.
module bcu_dpath #(
  parameter int unsigned RESULT_WIDTH = bcu_pkg::ResultWidthDef
) (
  input  logic                                clk_i,
  input  bcu_pkg::cmd_t                       cmd_i,
  output bcu_pkg::status_t                    status_o,
  input  logic [bcu_pkg::ArgWidth-1:0]        n_total_i,
  input  logic [bcu_pkg::ArgWidth-1:0]        k_choose_i,
  output logic [bcu_pkg::CoefWidth-1:0]       coefficient_o,
  output logic                                overflow_o
);
  import bcu_pkg::*;

  localparam int unsigned Rw     = RESULT_WIDTH;
  localparam int unsigned Chunks = (Rw + ChunkWidth - 1) / ChunkWidth;
  localparam int unsigned Cw     = Chunks * ChunkWidth;
  localparam int unsigned Pw     = Cw + ArgWidth;
  localparam int unsigned Hw     = Pw - Rw;
  localparam int unsigned CntW   = $clog2(Rw);

  logic [ArgWidth-1:0]           n_q, n_d;
  logic [ArgWidth-1:0]           k_q, k_d;
  logic [ArgWidth-1:0]           i_q, i_d;
  logic [Rw-1:0]                 c_q, c_d;
  logic [Cw-1:0]                 cshift_q, cshift_d;
  logic [Pw-1:0]                 acc_q, acc_d;
  logic [ChunkWidth+ArgWidth-1:0] pp_q, pp_d;
  logic [ArgWidth-1:0]           rem_q, rem_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CoefWidth-1:0]          coef_q, coef_d;
  logic                          ovf_q, ovf_d;

  logic [ArgWidth-1:0]           n_minus_k;
  logic [Hw-1:0]                 acc_hi;
  logic [ArgWidth:0]             trial;
  logic [ArgWidth:0]             trial_diff;
  logic                          trial_ge;
  logic [Cw-1:0]                 c_ext;

  assign n_minus_k  = n_q - k_q;
  assign acc_hi     = acc_q[Pw-1:Rw];
  assign trial      = {rem_q, acc_q[Rw-1]};
  assign trial_diff = trial - {1'b0, i_q};
  assign trial_ge   = (trial >= {1'b0, i_q});
  assign c_ext      = Cw'(c_q);

  assign status_o.k_gt_n    = (k_q > n_q);
  assign status_o.loop_done = (i_q > k_q);
  assign status_o.mul_last  = (cnt_q == CntW'(Chunks));
  assign status_o.div_ovf   = (acc_hi >= Hw'(i_q));
  assign status_o.div_last  = (cnt_q == CntW'(Rw - 1));

  always_comb begin
    n_d      = n_q;
    k_d      = k_q;
    i_d      = i_q;
    c_d      = c_q;
    cshift_d = cshift_q;
    acc_d    = acc_q;
    pp_d     = pp_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    coef_d   = coef_q;
    ovf_d    = ovf_q;

    if (cmd_i.load) begin
      n_d = n_total_i;
      k_d = k_choose_i;
    end

    if (cmd_i.prep) begin
      k_d = (k_q > n_minus_k) ? n_minus_k : k_q;
      c_d = Rw'(1);
      i_d = ArgWidth'(1);
    end

    if (cmd_i.mul_start) begin
      cshift_d = c_ext;
      acc_d    = '0;
      cnt_d    = '0;
    end

    if (cmd_i.mul_step) begin
      if (cnt_q != CntW'(Chunks)) begin
        pp_d     = cshift_q[Cw-1 -: ChunkWidth] * n_q;
        cshift_d = cshift_q << ChunkWidth;
      end
      if (cnt_q != '0) begin
        acc_d = (acc_q << ChunkWidth) + Pw'(pp_q);
      end
      cnt_d = cnt_q + CntW'(1);
    end

    if (cmd_i.div_start) begin
      rem_d = acc_hi[ArgWidth-1:0];
      cnt_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = trial_ge ? trial_diff[ArgWidth-1:0] : trial[ArgWidth-1:0];
      acc_d = {acc_q[Pw-1:Rw], acc_q[Rw-2:0], trial_ge};
      cnt_d = cnt_q + CntW'(1);
    end

    if (cmd_i.update) begin
      c_d = acc_q[Rw-1:0];
      n_d = n_q - ArgWidth'(1);
      i_d = i_q + ArgWidth'(1);
    end

    if (cmd_i.out_load) begin
      unique case (cmd_i.res_sel)
        RES_COEF: begin
          coef_d = c_ext[CoefWidth-1:0];
          ovf_d  = 1'b0;
        end
        RES_OVF: begin
          coef_d = '0;
          ovf_d  = 1'b1;
        end
        default: begin
          coef_d = '0;
          ovf_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    k_q      <= k_d;
    i_q      <= i_d;
    c_q      <= c_d;
    cshift_q <= cshift_d;
    acc_q    <= acc_d;
    pp_q     <= pp_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    coef_q   <= coef_d;
    ovf_q    <= ovf_d;
  end

  assign coefficient_o = coef_q;
  assign overflow_o    = ovf_q;

endmodule

@@ rtl/core/bcu_ctrl.sv @@
// Controller state machine of the binomial coefficient unit.
module bcu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bcu_pkg::status_t status_i,
  output bcu_pkg::cmd_t    cmd_o
);
  import bcu_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PREP = 8'b0000_0010,
    ST_LOOP = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_DCHK = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_SPARE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_ZERO;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.k_gt_n) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_ZERO;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (status_i.loop_done) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_COEF;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          state_d = ST_DCHK;
        end
      end
      ST_DCHK: begin
        if (status_i.div_ovf) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_OVF;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOOP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/binomial_coefficient_unit.sv @@
// Top level of the binomial coefficient unit: computes C(n,k) with an overflow flag.
//
// A request (n_total_i, k_choose_i) is accepted at a rising edge where in_valid_i is high
// and in_stall_o is low. One result (coefficient_o, overflow_o) follows for each request
// and is taken at an edge where out_valid_o is high and out_stall_i is low.
// The unit works on one request at a time; in_stall_o stays high from acceptance until
// the result has been placed in the output register.
// k is first replaced by n-k when that is smaller, giving k'. Each of the k' steps
// forms c*n in 32-bit chunks on one 32x32 multiplier (one chunk for RESULT_WIDTH up
// to 32) and divides by i on a restoring divider, one quotient bit per cycle. The
// next request is taken at the earliest in the cycle after the result is loaded; a
// step whose result would not fit ends the request early with overflow. Fewer than 18
// steps run at the default width.
// The result register frees the input side: a new request is taken while the previous
// result waits. If the receiver stalls and the next result is ready, the unit holds it
// internally until the output register is free.
// Reset is asynchronous and active low; it returns the unit to idle with no result
// pending. Results with overflow set always carry a zero coefficient.
module binomial_coefficient_unit #(
  parameter int unsigned RESULT_WIDTH = bcu_pkg::ResultWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bcu_pkg::ArgWidth-1:0]  n_total_i,
  input  logic [bcu_pkg::ArgWidth-1:0]  k_choose_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bcu_pkg::CoefWidth-1:0] coefficient_o,
  output logic                          overflow_o
);
  import bcu_pkg::*;

  cmd_t    cmd;
  status_t status;

  bcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bcu_dpath #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .n_total_i     (n_total_i),
    .k_choose_i    (k_choose_i),
    .coefficient_o (coefficient_o),
    .overflow_o    (overflow_o)
  );

  // An accepted request always sends the unit into its busy phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken without entering the busy phase");

  // An overflowed result carries a zero coefficient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (coefficient_o == '0))
    else $error("overflow result with nonzero coefficient");

  // A new result only appears after the unit was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(in_stall_o))
    else $error("result produced while idle");

  // A result load never overwrites one the receiver is still stalling on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load) |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

endmodule
